// File: sv/gsim_pkg.sv
// Package for the group-scaled int8 matrix-vector row engine.
// Holds the payload structs, the queue entry type, the back-end state enum
// and fixed constants. No dependencies.
package gsim_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_CNT_W = 3;
  localparam int unsigned LANE_SUM_W = 18;

  localparam logic signed [31:0] ACT_SCALE_RESET = 32'sd16777216;

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ROUND_BIAS = 64'd32;

  typedef struct packed {
    logic signed [7:0]  weight_0;
    logic signed [7:0]  weight_1;
    logic signed [7:0]  weight_2;
    logic signed [7:0]  weight_3;
    logic signed [7:0]  act_0;
    logic signed [7:0]  act_1;
    logic signed [7:0]  act_2;
    logic signed [7:0]  act_3;
    logic [2:0]         lanes_valid;
    logic signed [31:0] group_scale;
    logic               last_of_group;
    logic               last_of_row;
  } gsim_in_t;

  typedef struct packed {
    logic signed [31:0] row_value;
    logic               saturated;
  } gsim_out_t;

  // One closed group handed from front to back.
  typedef struct packed {
    logic signed [31:0] dot;
    logic signed [31:0] scale;
    logic               row_end;
  } gsim_grp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GMUL,
    BK_ACC,
    BK_MAG,
    BK_PLO,
    BK_PHI,
    BK_SUM,
    BK_OUT
  } gsim_back_state_e;

endpackage

// File: sv/group_scaled_int8_matvec.sv
// Top level of the group-scaled int8 matrix-vector row engine.
// Instantiates gsim_front, gsim_fifo and gsim_back; depends on gsim_pkg.
//
//   channel | signals                              | moves
//   --------+--------------------------------------+------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i    | one item of up to four pairs
//   out     | out_valid_o, out_ready_i, out_data_o | one row result at row close
//   cfg     | cfg_we_i, cfg_wdata_i                | activation scale, Q8.24
//
// The front takes one transaction per cycle while the group queue has room.
// The back pops each closed group, multiplies it by its group scale and
// accumulates it; at a row close it then forms magnitudes, two 32x32 partial
// products, does a rounding add and saturates into the output register.
// Within a row, groups of three or more items stream at one item per cycle;
// the extra row close steps stall the input once the queue is full.
// Reset clears the group dot, row accumulator, queue and output valid, and
// loads the activation scale with 1.0. A stalled output holds the back end.
module group_scaled_int8_matvec #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gsim_pkg::gsim_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gsim_pkg::gsim_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import gsim_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  gsim_grp_t push_data, pop_data;

  gsim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  gsim_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gsim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/gsim_front.sv
// Front end: accepts input transactions, sums the lane products into the
// running group dot product and emits a queue entry at each group close.
// Depends on gsim_pkg.
module gsim_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gsim_pkg::gsim_in_t  in_data_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output gsim_pkg::gsim_grp_t push_data_o
);
  import gsim_pkg::*;

  logic signed [7:0]            w      [LANES];
  logic signed [7:0]            a      [LANES];
  logic [LANE_CNT_W-1:0]        n_lanes;
  logic signed [LANE_SUM_W-1:0] lane_sum;
  logic signed [31:0]           dot_q, dot_d, dot_new;
  logic                         accept;
  logic                         grp_end;

  assign w[0] = in_data_i.weight_0;
  assign w[1] = in_data_i.weight_1;
  assign w[2] = in_data_i.weight_2;
  assign w[3] = in_data_i.weight_3;
  assign a[0] = in_data_i.act_0;
  assign a[1] = in_data_i.act_1;
  assign a[2] = in_data_i.act_2;
  assign a[3] = in_data_i.act_3;

  // Clamp lane count to the lanes that exist.
  assign n_lanes = (in_data_i.lanes_valid > LANE_CNT_W'(LANES)) ?
                   LANE_CNT_W'(LANES) : in_data_i.lanes_valid;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (LANE_CNT_W'(i) < n_lanes) begin
        lane_sum = lane_sum + LANE_SUM_W'(w[i] * a[i]);
      end
    end
  end

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign grp_end    = in_data_i.last_of_group || in_data_i.last_of_row;
  assign dot_new    = dot_q + 32'(lane_sum);

  assign push_valid_o        = accept && grp_end;
  assign push_data_o.dot     = dot_new;
  assign push_data_o.scale   = in_data_i.group_scale;
  assign push_data_o.row_end = in_data_i.last_of_row;

  always_comb begin
    dot_d = dot_q;
    if (accept) begin
      dot_d = grp_end ? '0 : dot_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
    end else begin
      dot_q <= dot_d;
    end
  end

endmodule

// File: sv/gsim_fifo.sv
// Short register queue of closed groups between front and back.
// Depends on gsim_pkg for the entry type.
module gsim_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  gsim_pkg::gsim_grp_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output gsim_pkg::gsim_grp_t pop_data_o
);
  import gsim_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  gsim_grp_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/gsim_back.sv
// Back end: scales each closed group into the 64-bit row accumulator and,
// at row close, applies the activation scale, rounds and saturates.
// Depends on gsim_pkg.
module gsim_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  gsim_pkg::gsim_grp_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gsim_pkg::gsim_out_t out_data_o
);
  import gsim_pkg::*;

  gsim_back_state_e   state_q, state_d;
  gsim_grp_t          grp_q;
  logic signed [31:0] act_scale_q;
  logic signed [63:0] gprod_q;
  logic signed [63:0] acc_q, acc_d;
  logic               row_sat_q, row_sat_d;
  logic               neg_q;
  logic [63:0]        mag_a_q, mag_a;
  logic [31:0]        mag_s_q, mag_s;
  logic [63:0]        plo_q, phi_q, m_q;
  logic               out_valid_q, out_valid_d;
  gsim_out_t          out_q, out_d;
  logic signed [64:0] acc_sum;
  logic               acc_ovf;
  logic               out_load;
  logic [63:0]        m_sat;
  logic               osat;

  assign acc_sum = {acc_q[63], acc_q} + {gprod_q[63], gprod_q};
  assign acc_ovf = acc_sum[64] != acc_sum[63];

  assign mag_a = acc_q[63] ? (~acc_q + 64'd1) : acc_q;
  assign mag_s = act_scale_q[31] ? (~act_scale_q + 32'd1) : act_scale_q;

  assign out_load = (state_q == BK_OUT) && (!out_valid_q || out_ready_i);

  // Clamp the rounded magnitude and restore the sign.
  always_comb begin
    m_sat = m_q;
    osat  = 1'b0;
    if (neg_q) begin
      if (m_q > NEG_LIMIT) begin
        m_sat = NEG_LIMIT;
        osat  = 1'b1;
      end
    end else if (m_q > POS_LIMIT) begin
      m_sat = POS_LIMIT;
      osat  = 1'b1;
    end
    out_d.row_value = neg_q ? (~m_sat[31:0] + 32'd1) : m_sat[31:0];
    out_d.saturated = row_sat_q || osat;
  end

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    acc_d       = acc_q;
    row_sat_d   = row_sat_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = BK_GMUL;
        end
      end
      BK_GMUL: state_d = BK_ACC;
      BK_ACC: begin
        if (acc_ovf) begin
          acc_d     = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          row_sat_d = 1'b1;
        end else begin
          acc_d = acc_sum[63:0];
        end
        state_d = grp_q.row_end ? BK_MAG : BK_IDLE;
      end
      BK_MAG: state_d = BK_PLO;
      BK_PLO: state_d = BK_PHI;
      BK_PHI: state_d = BK_SUM;
      BK_SUM: state_d = BK_OUT;
      BK_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          acc_d       = '0;
          row_sat_d   = 1'b0;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      acc_q       <= '0;
      row_sat_q   <= 1'b0;
      out_valid_q <= 1'b0;
      act_scale_q <= ACT_SCALE_RESET;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      row_sat_q   <= row_sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        act_scale_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      grp_q <= pop_data_i;
    end
    if (state_q == BK_GMUL) begin
      gprod_q <= grp_q.dot * grp_q.scale;
    end
    if (state_q == BK_MAG) begin
      mag_a_q <= mag_a;
      mag_s_q <= mag_s;
      neg_q   <= acc_q[63] != act_scale_q[31];
    end
    if (state_q == BK_PLO) begin
      plo_q <= 64'(mag_a_q[31:0]) * 64'(mag_s_q);
    end
    if (state_q == BK_PHI) begin
      phi_q <= 64'(mag_a_q[63:32]) * 64'(mag_s_q);
    end
    // Round Q.54 to Q16.16: add half an LSB, drop six more bits.
    if (state_q == BK_SUM) begin
      m_q <= (phi_q + {32'd0, plo_q[63:32]} + ROUND_BIAS) >> 6;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
